// ===== sv/monotonic_breakpoint_table_editor_defines.svh =====
// Assertion macros shared by the breakpoint table editor RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MONOTONIC_BREAKPOINT_TABLE_EDITOR_DEFINES_SVH
`define MONOTONIC_BREAKPOINT_TABLE_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBTE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBTE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mbte_pkg.sv =====
// Shared types and constants of the breakpoint table editor.
// No dependencies; imported by mbte_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mbte_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_VALUE_WIDTH = 16;

   localparam int FIELD_W   = 16;
   localparam int KIND_W    = 2;
   localparam int IDX_W     = 4;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 5;
   localparam int NEAR_W    = 16;
   localparam int MIN_ENTRIES = 2;

   localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd2;

   localparam logic [NEAR_W-1:0] NEAR_RESET = 16'd1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_FULL   = 3'd1,
      STATUS_ORDER  = 3'd2,
      STATUS_NONEAR = 3'd3,
      STATUS_FEW    = 3'd4,
      STATUS_INDEX  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_INSERT    = 2'd1,
      CELL_OVERWRITE = 2'd2,
      CELL_REMOVE    = 2'd3
   } cell_op_type;

   // Compare results a cell shows its neighbours (request against own entry)
   typedef struct packed {
      logic valid;
      logic src_gt;
      logic src_ge;
      logic src_le;
      logic dst_ge;
      logic dst_le;
      logic dst_lt;
      logic near;
   } cell_link_type;

   // Registered verdict of one cell, reduced at the top level
   typedef struct packed {
      logic add_bad;
      logic first_near;
      logic repl_bad;
   } cell_flag_type;

endpackage

`default_nettype wire

// ===== sv/mbte_cell.sv =====
// One table position: holds a source/destination pair, compares it with the
// request, and shifts to or from its neighbours. Depends on mbte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbte_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int TABLE_DEPTH = mbte_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = mbte_pkg::DEF_VALUE_WIDTH
) (
   input  wire                                           clock,
   input  wire                                           capture_i,
   input  mbte_pkg::cell_op_type                         op_i,
   input  wire  [$clog2(TABLE_DEPTH+1)-1:0]              count_i,
   input  wire  [VALUE_WIDTH-1:0]                        req_src_i,
   input  wire  [VALUE_WIDTH-1:0]                        req_dst_i,
   input  wire  [mbte_pkg::IDX_W-1:0]                    req_idx_i,
   input  wire  [mbte_pkg::NEAR_W-1:0]                   near_i,
   input  wire  [VALUE_WIDTH-1:0]                        new_src_i,
   input  wire  [VALUE_WIDTH-1:0]                        new_dst_i,
   input  mbte_pkg::cell_link_type                       left_i,
   input  mbte_pkg::cell_link_type                       right_i,
   input  wire  [VALUE_WIDTH-1:0]                        left_src_i,
   input  wire  [VALUE_WIDTH-1:0]                        left_dst_i,
   input  wire  [VALUE_WIDTH-1:0]                        right_src_i,
   input  wire  [VALUE_WIDTH-1:0]                        right_dst_i,
   output mbte_pkg::cell_link_type                       link_o,
   output logic [VALUE_WIDTH-1:0]                        src_o,
   output logic [VALUE_WIDTH-1:0]                        dst_o,
   output mbte_pkg::cell_flag_type                       flag_o
);
   import mbte_pkg::*;

   localparam int  CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int  XW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int  NW    = (VALUE_WIDTH > NEAR_W) ? VALUE_WIDTH : NEAR_W;
   localparam bit  FIRST = (CELL_INDEX == 0);

   logic [VALUE_WIDTH-1:0] src_ff, src_in;
   logic [VALUE_WIDTH-1:0] dst_ff, dst_in;
   logic                   is_at_ff, after_at_ff, del_from_ff;
   cell_flag_type          flag_ff;

   logic                   valid;
   logic [VALUE_WIDTH-1:0] diff;
   logic                   is_at;
   logic                   add_bad;
   logic                   first_near;
   logic                   repl_bad;
   logic                   del_from;
   cell_link_type          link;

   always_comb begin
      valid = (CNT_W'(CELL_INDEX) < count_i);
      diff  = (req_src_i > src_ff) ? (req_src_i - src_ff) : (src_ff - req_src_i);

      link.valid  = valid;
      link.src_gt = valid && (req_src_i > src_ff);
      link.src_ge = req_src_i >= src_ff;
      link.src_le = req_src_i <= src_ff;
      link.dst_ge = req_dst_i >= dst_ff;
      link.dst_le = req_dst_i <= dst_ff;
      link.dst_lt = req_dst_i < dst_ff;
      link.near   = valid && (NW'(diff) < NW'(near_i));

      // Sources rise along the row, so the insert place is where src_gt drops
      is_at   = (FIRST || left_i.src_gt) && !link.src_gt;
      add_bad = (valid && link.dst_ge)
             || (left_i.valid && (valid ? left_i.dst_le : left_i.dst_lt));

      // Near entries form one run; its head is the entry to overwrite
      first_near = link.near && !left_i.near;
      repl_bad   = (left_i.valid && !(left_i.src_ge && left_i.dst_ge))
                || (right_i.valid && !(right_i.src_le && right_i.dst_le));

      del_from = XW'(CELL_INDEX) >= XW'(req_idx_i);
   end

   assign link_o = link;

   always_ff @(posedge clock) begin
      if (capture_i) begin
         is_at_ff           <= is_at;
         after_at_ff        <= !link.src_gt && !is_at;
         del_from_ff        <= del_from;
         flag_ff.add_bad    <= is_at && add_bad;
         flag_ff.first_near <= first_near;
         flag_ff.repl_bad   <= first_near && repl_bad;
      end
   end

   always_comb begin
      src_in = src_ff;
      dst_in = dst_ff;
      case (op_i)
         CELL_INSERT: begin
            if (is_at_ff) begin
               src_in = new_src_i;
               dst_in = new_dst_i;
            end else if (after_at_ff) begin
               src_in = left_src_i;
               dst_in = left_dst_i;
            end
         end
         CELL_OVERWRITE: begin
            if (flag_ff.first_near) begin
               src_in = new_src_i;
               dst_in = new_dst_i;
            end
         end
         CELL_REMOVE: begin
            if (del_from_ff) begin
               src_in = right_src_i;
               dst_in = right_dst_i;
            end
         end
         default: begin
            src_in = src_ff;
            dst_in = dst_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      dst_ff <= dst_in;
   end

   assign src_o  = src_ff;
   assign dst_o  = dst_ff;
   assign flag_o = flag_ff;

endmodule

`default_nettype wire

// ===== sv/monotonic_breakpoint_table_editor.sv =====
// Top level of the breakpoint table editor: request/response streams, APB
// register, status decision and the row of mbte_cell. Depends on mbte_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "monotonic_breakpoint_table_editor_defines.svh"

// Sorted table of up to TABLE_DEPTH (source, destination) breakpoints, both
// rising. Each request adds, replaces or deletes one pair and returns one
// response with a status and the entry count afterwards. In the cycle a
// request is accepted every cell compares it with its own entry and its
// neighbours' and registers the verdict; in the next cycle the verdicts are
// OR-reduced, the status is decided and the row shifts or overwrites in one
// step. The next request is taken in the cycle after that; no new request is
// accepted while one is being evaluated. A response left waiting holds the
// evaluation step until it is taken. Table contents are not cleared by
// reset; only the count is, so no start-up pass is needed. near_distance
// (address 0) may be written only while idle.
module monotonic_breakpoint_table_editor #(
   parameter int TABLE_DEPTH = mbte_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = mbte_pkg::DEF_VALUE_WIDTH
) (
   input  wire         clock,
   input  wire         reset,
   // request
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // source[15:0], destination[31:16], index[35:32], zero
   input  wire  [1:0]  req_tuser,   // kind[1:0]
   // response
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // status[2:0], entry_count[7:3]
   // register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mbte_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int XW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [2:0] CSR_NEAR_ADDR = 3'd0;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NEAR_W-1:0]     near_ff, near_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [KIND_W-1:0]     kind_ff;
   logic [VALUE_WIDTH-1:0] src_ff, dst_ff;
   logic [IDX_W-1:0]      idx_ff;

   logic [VALUE_WIDTH-1:0] req_src, req_dst;
   logic [IDX_W-1:0]      req_idx;
   logic                  capture;
   logic                  out_free;
   logic                  commit;
   logic                  csr_write;

   logic                  any_add_bad, any_near, any_repl_bad;
   logic [TABLE_DEPTH-1:0] near_vec;
   logic                  table_full;
   status_type            dec_status;
   cell_op_type           dec_op;
   cell_op_type           cell_op;
   logic [CNT_W-1:0]      dec_count;

   cell_link_type         link_vec [TABLE_DEPTH];
   cell_flag_type         flag_vec [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] src_vec [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] dst_vec [TABLE_DEPTH];

   // Mask the request values to the stored width
   always_comb begin
      req_src = '0;
      req_dst = '0;
      for (int b = 0; b < VALUE_WIDTH; b++) begin
         if (b < FIELD_W) begin
            req_src[b] = req_tdata[b];
            req_dst[b] = req_tdata[FIELD_W + b];
         end
      end
      req_idx = req_tdata[2*FIELD_W +: IDX_W];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign capture    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_EVAL) && out_free;
   assign cell_op    = commit ? dec_op : CELL_HOLD;

   // Row of cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      cell_link_type          left_link, right_link;
      logic [VALUE_WIDTH-1:0] left_src, left_dst, right_src, right_dst;

      if (g == 0) begin : g_first
         assign left_link = '0;
         assign left_src  = '0;
         assign left_dst  = '0;
      end else begin : g_mid_l
         assign left_link = link_vec[g-1];
         assign left_src  = src_vec[g-1];
         assign left_dst  = dst_vec[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
         assign right_link = '0;
         assign right_src  = '0;
         assign right_dst  = '0;
      end else begin : g_mid_r
         assign right_link = link_vec[g+1];
         assign right_src  = src_vec[g+1];
         assign right_dst  = dst_vec[g+1];
      end

      mbte_cell #(
         .CELL_INDEX  (g),
         .TABLE_DEPTH (TABLE_DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .capture_i   (capture),
         .op_i        (cell_op),
         .count_i     (count_ff),
         .req_src_i   (req_src),
         .req_dst_i   (req_dst),
         .req_idx_i   (req_idx),
         .near_i      (near_ff),
         .new_src_i   (src_ff),
         .new_dst_i   (dst_ff),
         .left_i      (left_link),
         .right_i     (right_link),
         .left_src_i  (left_src),
         .left_dst_i  (left_dst),
         .right_src_i (right_src),
         .right_dst_i (right_dst),
         .link_o      (link_vec[g]),
         .src_o       (src_vec[g]),
         .dst_o       (dst_vec[g]),
         .flag_o      (flag_vec[g])
      );
   end

   always_comb begin
      any_add_bad  = 1'b0;
      any_repl_bad = 1'b0;
      for (int c = 0; c < TABLE_DEPTH; c++) begin
         near_vec[c]  = flag_vec[c].first_near;
         any_add_bad  = any_add_bad | flag_vec[c].add_bad;
         any_repl_bad = any_repl_bad | flag_vec[c].repl_bad;
      end
      any_near = |near_vec;
   end

   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      dec_status = STATUS_OK;
      dec_op     = CELL_HOLD;
      dec_count  = count_ff;
      case (kind_ff)
         KIND_ADD: begin
            if (table_full) begin
               dec_status = STATUS_FULL;
            end else if (any_add_bad) begin
               dec_status = STATUS_ORDER;
            end else begin
               dec_op    = CELL_INSERT;
               dec_count = count_ff + CNT_W'(1);
            end
         end
         KIND_REPLACE: begin
            if (table_full) begin
               dec_status = STATUS_FULL;
            end else if (!any_near) begin
               dec_status = STATUS_NONEAR;
            end else if (count_ff < CNT_W'(MIN_ENTRIES) || any_repl_bad) begin
               dec_status = STATUS_ORDER;
            end else begin
               dec_op = CELL_OVERWRITE;
            end
         end
         KIND_DELETE: begin
            if (count_ff <= CNT_W'(MIN_ENTRIES)) begin
               dec_status = STATUS_FEW;
            end else if (XW'(idx_ff) >= XW'(count_ff)) begin
               dec_status = STATUS_INDEX;
            end else begin
               dec_op    = CELL_REMOVE;
               dec_count = count_ff - CNT_W'(1);
            end
         end
         default: begin
            dec_status = STATUS_OK;
            dec_op     = CELL_HOLD;
         end
      endcase
   end

   // Control state
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      near_in      = (csr_write && csr_paddr == CSR_NEAR_ADDR) ?
                     csr_pwdata[NEAR_W-1:0] : near_ff;
      case (state_ff)
         ST_IDLE: begin
            if (capture) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (commit) begin
               state_in     = ST_IDLE;
               count_in     = dec_count;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         near_ff      <= NEAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         near_ff      <= near_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload
   always_ff @(posedge clock) begin
      if (capture) begin
         kind_ff <= req_tuser;
         src_ff  <= req_src;
         dst_ff  <= req_dst;
         idx_ff  <= req_idx;
      end
      if (commit) begin
         status_ff    <= dec_status;
         rsp_count_ff <= COUNT_W'(dec_count);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, status_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_NEAR_ADDR) ? 32'(near_ff) : 32'd0;

   `MBTE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
   `MBTE_ASSERT_NXT(a_insert_count, clock, reset, commit && dec_op == CELL_INSERT, count_ff == $past(count_ff) + CNT_W'(1), "insert did not raise the count")
   `MBTE_ASSERT_NXT(a_commit_rsp, clock, reset, commit, rsp_valid_ff, "committed request left no response")
   `MBTE_ASSERT_NXT(a_capture_eval, clock, reset, capture, state_ff == ST_EVAL && $stable(count_ff), "accepted request did not enter evaluation")
   `MBTE_ASSERT_IMP(a_one_near, clock, reset, state_ff == ST_EVAL, $onehot0(near_vec), "more than one overwrite target")

endmodule

`default_nettype wire
